// ===== rtl/core/pcc_pkg.sv =====
// Package for the parity constraint checker: codes, microcode types and the control store.
package pcc_pkg;

  // Fixed field widths and defaults.
  localparam int POS_W      = 10;
  localparam int COUNT_W    = 16;
  localparam int UPC_W      = 5;
  localparam int NODES_DEF  = 1024;
  localparam logic [POS_W-1:0]   SEQ_RESET = 10'd1023;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_SAME    = 3'd1,
    ST_CONTRA  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_HALTED  = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    U_NOP,
    U_LATCH,
    U_LOAD_A,
    U_FIND_STEP,
    U_COMP_INIT,
    U_COMP_WR,
    U_FIND_END,
    U_RESOLVE,
    U_RESPOND,
    U_HALT_RSP,
    U_RANGE_RSP,
    U_CLR_INIT,
    U_CLR_WR,
    U_CLR_DONE
  } uop_e;

  // Jump conditions; a false condition falls through to the next step.
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_START,
    C_IS_CLEAR,
    C_HALTED,
    C_BAD_RANGE,
    C_NOT_ROOT,
    C_AT_ROOT,
    C_PH_A,
    C_CLR_MORE,
    C_BOOT
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  // Step addresses of the control program.
  localparam upc_t A_WAIT     = 5'd0;
  localparam upc_t A_DISP_CLR = 5'd1;
  localparam upc_t A_DISP_HLT = 5'd2;
  localparam upc_t A_DISP_RNG = 5'd3;
  localparam upc_t A_LOAD_A   = 5'd4;
  localparam upc_t A_FIND_RD  = 5'd5;
  localparam upc_t A_FIND_CHK = 5'd6;
  localparam upc_t A_COMP_INI = 5'd7;
  localparam upc_t A_COMP_CHK = 5'd8;
  localparam upc_t A_COMP_WR  = 5'd9;
  localparam upc_t A_FIND_END = 5'd10;
  localparam upc_t A_RESOLVE  = 5'd11;
  localparam upc_t A_RESPOND  = 5'd12;
  localparam upc_t A_R_HALT   = 5'd13;
  localparam upc_t A_R_RANGE  = 5'd14;
  localparam upc_t A_CLR_INIT = 5'd15;
  localparam upc_t A_CLR_WR   = 5'd16;
  localparam upc_t A_CLR_END  = 5'd17;
  localparam upc_t A_CLR_RSP  = 5'd18;

  // Control store: one word per step.
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    w = '{op: U_NOP, cond: C_ALWAYS, target: A_WAIT};
    case (addr)
      A_WAIT:     w = '{op: U_LATCH,     cond: C_NO_START,  target: A_WAIT};
      A_DISP_CLR: w = '{op: U_NOP,       cond: C_IS_CLEAR,  target: A_CLR_INIT};
      A_DISP_HLT: w = '{op: U_NOP,       cond: C_HALTED,    target: A_R_HALT};
      A_DISP_RNG: w = '{op: U_NOP,       cond: C_BAD_RANGE, target: A_R_RANGE};
      A_LOAD_A:   w = '{op: U_LOAD_A,    cond: C_NONE,      target: A_WAIT};
      A_FIND_RD:  w = '{op: U_NOP,       cond: C_NONE,      target: A_WAIT};
      A_FIND_CHK: w = '{op: U_FIND_STEP, cond: C_NOT_ROOT,  target: A_FIND_RD};
      A_COMP_INI: w = '{op: U_COMP_INIT, cond: C_NONE,      target: A_WAIT};
      A_COMP_CHK: w = '{op: U_NOP,       cond: C_AT_ROOT,   target: A_FIND_END};
      A_COMP_WR:  w = '{op: U_COMP_WR,   cond: C_ALWAYS,    target: A_COMP_CHK};
      A_FIND_END: w = '{op: U_FIND_END,  cond: C_PH_A,      target: A_FIND_RD};
      A_RESOLVE:  w = '{op: U_RESOLVE,   cond: C_NONE,      target: A_WAIT};
      A_RESPOND:  w = '{op: U_RESPOND,   cond: C_ALWAYS,    target: A_WAIT};
      A_R_HALT:   w = '{op: U_HALT_RSP,  cond: C_ALWAYS,    target: A_RESPOND};
      A_R_RANGE:  w = '{op: U_RANGE_RSP, cond: C_ALWAYS,    target: A_RESPOND};
      A_CLR_INIT: w = '{op: U_CLR_INIT,  cond: C_NONE,      target: A_WAIT};
      A_CLR_WR:   w = '{op: U_CLR_WR,    cond: C_CLR_MORE,  target: A_CLR_WR};
      A_CLR_END:  w = '{op: U_CLR_DONE,  cond: C_BOOT,      target: A_WAIT};
      A_CLR_RSP:  w = '{op: U_NOP,       cond: C_ALWAYS,    target: A_RESPOND};
      default:    w = '{op: U_NOP,       cond: C_ALWAYS,    target: A_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pcc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered every cycle.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/parity_constraint_checker.sv =====
// Top level of the parity constraint checker: microcoded union-find with parity.
//
//  channel  | signals                                      | transfer when
//  ---------+----------------------------------------------+----------------------------
//  claim in | start, busy, mode_i, first_pos_i, last_pos_i, | start high and busy low
//           | odd_i                                        |
//  result   | result_valid_o, status_o, accepted_count_o   | every cycle result_valid_o
//  config   | cfg_valid_i, cfg_ready_o, cfg_wdata_i        | cfg_valid_i and cfg_ready_o
//
// A claim's duration grows with the parent chain lengths ha and hb of its two prefix nodes;
// each hop costs one table read on the walk to the root and one read plus write on the
// compression pass. Halted and out-of-range claims answer without walking the table.
// A clear writes one table entry per cycle.
// After reset the same clearing pass runs with busy high and no result.
// The result strobe lasts one cycle; the receiver cannot stall, and config is always ready.
module parity_constraint_checker #(
  parameter int NODES = pcc_pkg::NODES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode_i,
  input  logic [pcc_pkg::POS_W-1:0]    first_pos_i,
  input  logic [pcc_pkg::POS_W-1:0]    last_pos_i,
  input  logic                         odd_i,
  output logic                         result_valid_o,
  output logic [2:0]                   status_o,
  output logic [pcc_pkg::COUNT_W-1:0]  accepted_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pcc_pkg::POS_W-1:0]    cfg_wdata_i
);

  import pcc_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int DW = NW + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

  // Sequencer and control state.
  upc_t                upc_q, upc_d;
  logic                boot_q, boot_d;
  logic                halted_q, halted_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  status_e             status_q, status_d;
  logic                rvalid_q, rvalid_d;
  logic [POS_W-1:0]    seq_q;

  // Datapath registers.
  logic                mode_q, mode_d;
  logic [POS_W-1:0]    first_q, first_d;
  logic [POS_W-1:0]    last_q, last_d;
  logic                odd_q, odd_d;
  logic [NW-1:0]       node_q, node_d;
  logic [NW-1:0]       orig_q, orig_d;
  logic [NW-1:0]       root_q, root_d;
  logic [NW-1:0]       ra_q, ra_d;
  logic [NW-1:0]       rb_q, rb_d;
  logic [NW-1:0]       clr_q, clr_d;
  logic                acc_q, acc_d;
  logic                p_q, p_d;
  logic                pa_q, pa_d;
  logic                pb_q, pb_d;
  logic                ph_q, ph_d;

  // Table port signals.
  logic                we;
  logic [NW-1:0]       waddr;
  logic [DW-1:0]       wdata;
  logic [DW-1:0]       rdata;
  logic [NW-1:0]       rd_parent;
  logic                rd_par;

  uword_t              uw;
  logic                take;
  logic                cond_ok;
  logic                is_root;
  logic                bad_range;
  logic [NW-1:0]       a_node;
  logic [NW-1:0]       b_node;

  // Parent link and parity stored together in one word per node.
  pcc_ram #(
    .WIDTH(DW),
    .DEPTH(NODES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (node_q),
    .rdata_o (rdata)
  );

  assign rd_parent = rdata[DW-1:1];
  assign rd_par    = rdata[0];
  assign uw        = ucode(upc_q);
  assign busy      = (upc_q != A_WAIT);
  assign take      = start && !busy;
  assign is_root   = (rd_parent == node_q);
  assign a_node    = NW'(first_q - POS_W'(1));
  assign b_node    = NW'(last_q);

  // A zero first position has no prefix node, so it counts as out of range.
  assign bad_range = (first_q == '0) || (first_q > seq_q) || (last_q > seq_q) ||
                     (32'(last_q) >= NODES) || (32'(first_q) > NODES);

  // Condition evaluation for the jump field.
  always_comb begin
    case (uw.cond)
      C_NONE:      cond_ok = 1'b0;
      C_ALWAYS:    cond_ok = 1'b1;
      C_NO_START:  cond_ok = !start;
      C_IS_CLEAR:  cond_ok = !mode_q;
      C_HALTED:    cond_ok = halted_q;
      C_BAD_RANGE: cond_ok = bad_range;
      C_NOT_ROOT:  cond_ok = !is_root;
      C_AT_ROOT:   cond_ok = (node_q == root_q);
      C_PH_A:      cond_ok = !ph_q;
      C_CLR_MORE:  cond_ok = (clr_q != LAST_NODE);
      C_BOOT:      cond_ok = boot_q;
      default:     cond_ok = 1'b0;
    endcase
  end

  // Next step of the sequencer.
  always_comb begin
    if (cond_ok) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  // Datapath actions selected by the control word.
  always_comb begin
    boot_d   = boot_q;
    halted_d = halted_q;
    count_d  = count_q;
    status_d = status_q;
    rvalid_d = 1'b0;
    mode_d   = mode_q;
    first_d  = first_q;
    last_d   = last_q;
    odd_d    = odd_q;
    node_d   = node_q;
    orig_d   = orig_q;
    root_d   = root_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    clr_d    = clr_q;
    acc_d    = acc_q;
    p_d      = p_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    ph_d     = ph_q;
    we       = 1'b0;
    waddr    = node_q;
    wdata    = {root_q, p_q};
    case (uw.op)
      U_NOP: begin
      end
      U_LATCH: begin
        if (take) begin
          mode_d  = mode_i;
          first_d = first_pos_i;
          last_d  = last_pos_i;
          odd_d   = odd_i;
        end
      end
      U_LOAD_A: begin
        node_d = a_node;
        orig_d = a_node;
        acc_d  = 1'b0;
        ph_d   = 1'b0;
      end
      U_FIND_STEP: begin
        // Follow one parent link, folding in the parity to the parent.
        if (!is_root) begin
          acc_d  = acc_q ^ rd_par;
          node_d = rd_parent;
        end
      end
      U_COMP_INIT: begin
        root_d = node_q;
        p_d    = acc_q;
        node_d = orig_q;
      end
      U_COMP_WR: begin
        // Point this node straight at the root with its parity to the root.
        we     = 1'b1;
        waddr  = node_q;
        wdata  = {root_q, p_q};
        p_d    = p_q ^ rd_par;
        node_d = rd_parent;
      end
      U_FIND_END: begin
        if (!ph_q) begin
          ra_d   = root_q;
          pa_d   = acc_q;
          node_d = b_node;
          orig_d = b_node;
          acc_d  = 1'b0;
          ph_d   = 1'b1;
        end else begin
          rb_d = root_q;
          pb_d = acc_q;
        end
      end
      U_RESOLVE: begin
        if (ra_q == rb_q) begin
          if ((pa_q ^ pb_q) != odd_q) begin
            halted_d = 1'b1;
            status_d = ST_CONTRA;
          end else begin
            status_d = ST_SAME;
          end
        end else begin
          // Hang the second tree under the first root.
          we       = 1'b1;
          waddr    = rb_q;
          wdata    = {ra_q, pa_q ^ pb_q ^ odd_q};
          status_d = ST_NEW;
        end
        if (!((ra_q == rb_q) && ((pa_q ^ pb_q) != odd_q)) && (count_q != COUNT_MAX)) begin
          count_d = count_q + COUNT_W'(1);
        end
      end
      U_RESPOND: begin
        rvalid_d = 1'b1;
      end
      U_HALT_RSP: begin
        status_d = ST_HALTED;
      end
      U_RANGE_RSP: begin
        status_d = ST_RANGE;
        halted_d = 1'b1;
      end
      U_CLR_INIT: begin
        clr_d    = '0;
        halted_d = 1'b0;
        count_d  = '0;
        status_d = ST_CLEARED;
      end
      U_CLR_WR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {clr_q, 1'b0};
        clr_d = clr_q + NW'(1);
      end
      U_CLR_DONE: begin
        boot_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q    <= A_CLR_INIT;
      boot_q   <= 1'b1;
      halted_q <= 1'b0;
      count_q  <= '0;
      status_q <= ST_CLEARED;
      rvalid_q <= 1'b0;
      seq_q    <= SEQ_RESET;
    end else begin
      upc_q    <= upc_d;
      boot_q   <= boot_d;
      halted_q <= halted_d;
      count_q  <= count_d;
      status_q <= status_d;
      rvalid_q <= rvalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seq_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    first_q <= first_d;
    last_q  <= last_d;
    odd_q   <= odd_d;
    node_q  <= node_d;
    orig_q  <= orig_d;
    root_q  <= root_d;
    ra_q    <= ra_d;
    rb_q    <= rb_d;
    clr_q   <= clr_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    ph_q    <= ph_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign result_valid_o   = rvalid_q;
  assign status_o         = status_q;
  assign accepted_count_o = count_q;

endmodule

// ===== rtl/core/pcc_checker.sv =====
// Port-level assertions for the parity constraint checker, bound to the top level.
module pcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid_o,
  input logic [2:0]                   status_o,
  input logic [pcc_pkg::COUNT_W-1:0]  accepted_count_o
);

  import pcc_pkg::*;

  // An accepted claim or clear keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a transfer");

  // A result only appears once the block has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // The strobe marks one result for a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // A clear always reports an empty count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_CLEARED)) |-> (accepted_count_o == '0))
    else $error("clear reported a non-zero count");

endmodule

bind parity_constraint_checker pcc_checker u_pcc_checker (.*);
